@@ src/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths, beat types and divider request/response types for the
// rgb to hsl converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS     = 16;
  localparam int SAT_BITS     = 16;

  localparam int LIGHT_BITS = CHANNEL_BITS + 1;
  localparam int NUM_BITS   = CHANNEL_BITS + 4;
  localparam int HDEN_BITS  = CHANNEL_BITS + 3;
  localparam int SQ_BITS    = SAT_BITS + 1;
  localparam int HQ_BITS    = HUE_BITS + 1;

  localparam int DIV_STEPS = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;
  // accept edge to result-taking edge
  localparam int PIPE_LAT  = DIV_STEPS + 5;

  localparam logic [CHANNEL_BITS-1:0] FULL     = {CHANNEL_BITS{1'b1}};
  localparam logic [LIGHT_BITS-1:0]   FULL_TWO = {FULL, 1'b0};

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]   hue_out;
    logic [SAT_BITS-1:0]   saturation_out;
    logic [LIGHT_BITS-1:0] lightness_twice;
  } hsl_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] sat_num;
    logic [CHANNEL_BITS-1:0] sat_den;
    logic [HDEN_BITS-1:0]    hue_num;
    logic [HDEN_BITS-1:0]    hue_den;
    logic                    sat_zero;
    logic                    hue_zero;
    logic [LIGHT_BITS-1:0]   light;
  } div_req_t;

  typedef struct packed {
    logic [SQ_BITS-1:0]    sat_q;
    logic [HQ_BITS-1:0]    hue_q;
    logic                  sat_zero;
    logic                  hue_zero;
    logic [LIGHT_BITS-1:0] light;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ src/rhc_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rhc_div_pipe
// Pipelined restoring divider with two lanes, saturation and hue, one
// quotient bit per lane per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_pipe (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             req_valid,
  input  wire rhc_pkg::div_req_t req,
  output logic                  rsp_valid,
  output rhc_pkg::div_rsp_t     rsp
);

  typedef struct packed {
    logic [rhc_pkg::CHANNEL_BITS-1:0] sat_rem;
    logic [rhc_pkg::CHANNEL_BITS-1:0] sat_den;
    logic [rhc_pkg::SQ_BITS-1:0]      sat_q;
    logic [rhc_pkg::HDEN_BITS-1:0]    hue_rem;
    logic [rhc_pkg::HDEN_BITS-1:0]    hue_den;
    logic [rhc_pkg::HQ_BITS-1:0]      hue_q;
    logic                             sat_zero;
    logic                             hue_zero;
    logic [rhc_pkg::LIGHT_BITS-1:0]   light;
  } stage_t;

  logic   v_r  [rhc_pkg::DIV_STEPS+1];
  stage_t st_r [rhc_pkg::DIV_STEPS+1];
  stage_t st0_nxt;

  // top quotient bit: plain compare, no shift
  always_comb begin
    st0_nxt.sat_den  = req.sat_den;
    st0_nxt.hue_den  = req.hue_den;
    st0_nxt.sat_zero = req.sat_zero;
    st0_nxt.hue_zero = req.hue_zero;
    st0_nxt.light    = req.light;
    if (req.sat_num >= req.sat_den) begin
      st0_nxt.sat_rem = req.sat_num - req.sat_den;
      st0_nxt.sat_q   = {{(rhc_pkg::SQ_BITS-1){1'b0}}, 1'b1};
    end else begin
      st0_nxt.sat_rem = req.sat_num;
      st0_nxt.sat_q   = '0;
    end
    if (req.hue_num >= req.hue_den) begin
      st0_nxt.hue_rem = req.hue_num - req.hue_den;
      st0_nxt.hue_q   = {{(rhc_pkg::HQ_BITS-1){1'b0}}, 1'b1};
    end else begin
      st0_nxt.hue_rem = req.hue_num;
      st0_nxt.hue_q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= req_valid;
    end
    st_r[0] <= st0_nxt;
  end

  for (genvar k = 1; k <= rhc_pkg::DIV_STEPS; k++) begin : g_step
    stage_t                         stp_nxt;
    logic [rhc_pkg::CHANNEL_BITS:0] sat_sh;
    logic [rhc_pkg::CHANNEL_BITS:0] sat_diff;
    logic [rhc_pkg::HDEN_BITS:0]    hue_sh;
    logic [rhc_pkg::HDEN_BITS:0]    hue_diff;

    always_comb begin
      stp_nxt  = st_r[k-1];
      sat_sh   = {st_r[k-1].sat_rem, 1'b0};
      sat_diff = sat_sh - {1'b0, st_r[k-1].sat_den};
      hue_sh   = {st_r[k-1].hue_rem, 1'b0};
      hue_diff = hue_sh - {1'b0, st_r[k-1].hue_den};
      if (k <= rhc_pkg::SAT_BITS) begin
        if (sat_sh >= {1'b0, st_r[k-1].sat_den}) begin
          stp_nxt.sat_rem = sat_diff[rhc_pkg::CHANNEL_BITS-1:0];
          stp_nxt.sat_q   = {st_r[k-1].sat_q[rhc_pkg::SQ_BITS-2:0], 1'b1};
        end else begin
          stp_nxt.sat_rem = sat_sh[rhc_pkg::CHANNEL_BITS-1:0];
          stp_nxt.sat_q   = {st_r[k-1].sat_q[rhc_pkg::SQ_BITS-2:0], 1'b0};
        end
      end
      if (k <= rhc_pkg::HUE_BITS) begin
        if (hue_sh >= {1'b0, st_r[k-1].hue_den}) begin
          stp_nxt.hue_rem = hue_diff[rhc_pkg::HDEN_BITS-1:0];
          stp_nxt.hue_q   = {st_r[k-1].hue_q[rhc_pkg::HQ_BITS-2:0], 1'b1};
        end else begin
          stp_nxt.hue_rem = hue_sh[rhc_pkg::HDEN_BITS-1:0];
          stp_nxt.hue_q   = {st_r[k-1].hue_q[rhc_pkg::HQ_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
      st_r[k] <= stp_nxt;
    end
  end

  assign rsp_valid    = v_r[rhc_pkg::DIV_STEPS];
  assign rsp.sat_q    = st_r[rhc_pkg::DIV_STEPS].sat_q;
  assign rsp.hue_q    = st_r[rhc_pkg::DIV_STEPS].hue_q;
  assign rsp.sat_zero = st_r[rhc_pkg::DIV_STEPS].sat_zero;
  assign rsp.hue_zero = st_r[rhc_pkg::DIV_STEPS].hue_zero;
  assign rsp.light    = st_r[rhc_pkg::DIV_STEPS].light;

endmodule

`default_nettype wire

@@ src/rgb_to_hsl_converter_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_unit
// Converts one rgb pixel a cycle into hue, saturation and doubled lightness.
//
//   channel  ports                      direction  handshake
//   input    start, busy, in_data       in         start && !busy
//   result   out_valid, out_data        out        out_valid strobe, 1 cycle
//
// one pixel accepted every cycle; busy is never raised
// pipeline: three front stages, 17 divider stages, output register
// the divider pipeline gives one quotient bit per stage on both lanes
// synchronous active-low reset clears all valid bits, beats in flight are lost
// the receiver takes every result in its strobe cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_converter_unit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire rhc_pkg::pixel_t in_data,
  output logic                 out_valid,
  output rhc_pkg::hsl_t        out_data
);

  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  localparam int CB = rhc_pkg::CHANNEL_BITS;
  localparam int NB = rhc_pkg::NUM_BITS;

  logic accept;

  // stage 1: min, max, sector
  logic          s1_v_r;
  logic [CB-1:0] s1_r_r, s1_g_r, s1_b_r, s1_mx_r, s1_mn_r;
  logic [1:0]    s1_sec_r;
  logic [CB-1:0] mx_nxt, mn_nxt;
  logic [1:0]    sec_nxt;

  // stage 2: delta, sum, raw hue numerator
  logic                  s2_v_r;
  logic [CB-1:0]         s2_delta_r;
  logic [CB:0]           s2_sum_r;
  logic signed [NB-1:0]  s2_num_r;
  logic [CB-1:0]         delta_nxt;
  logic [CB:0]           sum_nxt;
  logic signed [NB-1:0]  num_nxt;
  logic signed [NB-1:0]  r_x, g_x, b_x, d_x;

  // stage 3: wrap, divisors, special cases
  logic                  req_v_r;
  rhc_pkg::div_req_t     req_r;
  rhc_pkg::div_req_t     req_nxt;
  logic signed [NB-1:0]  d6_x, num_wrap;
  logic [CB:0]           den_full;

  rhc_pkg::div_rsp_t     rsp;
  logic                  rsp_valid;

  logic                  out_valid_r;
  rhc_pkg::hsl_t         out_data_r;
  rhc_pkg::hsl_t         out_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    mx_nxt = in_data.red_in;
    mn_nxt = in_data.red_in;
    if (in_data.green_in > mx_nxt) mx_nxt = in_data.green_in;
    if (in_data.blue_in > mx_nxt)  mx_nxt = in_data.blue_in;
    if (in_data.green_in < mn_nxt) mn_nxt = in_data.green_in;
    if (in_data.blue_in < mn_nxt)  mn_nxt = in_data.blue_in;
    if (mx_nxt == in_data.red_in && mx_nxt != in_data.green_in) begin
      sec_nxt = SEC_RED;
    end else if (mx_nxt == in_data.green_in && mx_nxt != in_data.blue_in) begin
      sec_nxt = SEC_GREEN;
    end else begin
      sec_nxt = SEC_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
    s1_r_r   <= in_data.red_in;
    s1_g_r   <= in_data.green_in;
    s1_b_r   <= in_data.blue_in;
    s1_mx_r  <= mx_nxt;
    s1_mn_r  <= mn_nxt;
    s1_sec_r <= sec_nxt;
  end

  always_comb begin
    delta_nxt = s1_mx_r - s1_mn_r;
    sum_nxt   = {1'b0, s1_mx_r} + {1'b0, s1_mn_r};
    r_x = signed'({{(NB-CB){1'b0}}, s1_r_r});
    g_x = signed'({{(NB-CB){1'b0}}, s1_g_r});
    b_x = signed'({{(NB-CB){1'b0}}, s1_b_r});
    d_x = signed'({{(NB-CB){1'b0}}, delta_nxt});
    case (s1_sec_r)
      SEC_RED:   num_nxt = g_x - b_x;
      SEC_GREEN: num_nxt = (d_x <<< 1) + b_x - r_x;
      default:   num_nxt = (d_x <<< 2) + r_x - g_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_delta_r <= delta_nxt;
    s2_sum_r   <= sum_nxt;
    s2_num_r   <= num_nxt;
  end

  always_comb begin
    d6_x     = signed'({{(NB-CB){1'b0}}, s2_delta_r});
    d6_x     = (d6_x <<< 2) + (d6_x <<< 1);
    num_wrap = (s2_num_r < 0) ? (s2_num_r + d6_x) : s2_num_r;
    den_full = (s2_sum_r < {1'b0, rhc_pkg::FULL}) ? s2_sum_r
                                                  : (rhc_pkg::FULL_TWO - s2_sum_r);
    req_nxt.sat_num  = s2_delta_r;
    req_nxt.sat_den  = den_full[CB-1:0];
    req_nxt.hue_num  = num_wrap[rhc_pkg::HDEN_BITS-1:0];
    req_nxt.hue_den  = d6_x[rhc_pkg::HDEN_BITS-1:0];
    req_nxt.sat_zero = (s2_sum_r == '0) || (s2_sum_r == rhc_pkg::FULL_TWO);
    req_nxt.hue_zero = (s2_delta_r == '0);
    req_nxt.light    = s2_sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else begin
      req_v_r <= s2_v_r;
    end
    req_r <= req_nxt;
  end

  rhc_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_v_r),
    .req       (req_r),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  always_comb begin
    out_nxt.lightness_twice = rsp.light;
    if (rsp.hue_zero) begin
      out_nxt.hue_out = '0;
    end else begin
      out_nxt.hue_out = rsp.hue_q[rhc_pkg::HUE_BITS-1:0];
    end
    if (rsp.sat_zero) begin
      out_nxt.saturation_out = '0;
    end else if (rsp.sat_q[rhc_pkg::SAT_BITS]) begin
      out_nxt.saturation_out = '1;
    end else begin
      out_nxt.saturation_out = rsp.sat_q[rhc_pkg::SAT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rsp_valid;
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ src/rhc_checker.sv @@
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks on the rgb to hsl converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            out_valid,
  input wire rhc_pkg::hsl_t   out_data
);

  // every beat taken comes out after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(rhc_pkg::PIPE_LAT) out_valid)
    else $error("accepted beat without result");

  // no result without an accepted beat
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, rhc_pkg::PIPE_LAT))
    else $error("result without accepted beat");

  a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.lightness_twice <= rhc_pkg::FULL_TWO))
    else $error("lightness out of range");

  // black and white carry neither hue nor saturation
  a_black_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.lightness_twice == '0 ||
                   out_data.lightness_twice == rhc_pkg::FULL_TWO))
    |-> (out_data.saturation_out == '0 && out_data.hue_out == '0))
    else $error("black or white with color");

endmodule

bind rgb_to_hsl_converter_unit rhc_checker u_rhc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
